/* rtl/ccts_pkg.sv */
// Shared types and constants for the cycle-count timestamp splitter.
// Used by ccts_serial_div and cycle_count_timestamp_split_unit.
// No dependencies.
package ccts_pkg;

    // Field and register widths fixed by the interface
    localparam int CLK_MHZ_W  = 10;
    localparam int IN_W       = 32;
    localparam int WRAP_W     = 32;
    localparam int SECONDS_W  = 45;
    localparam int SUBSEC_W   = 10;
    localparam int TOTAL_US_W = 64;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register map: index taken from the word address
    localparam logic REG_CLOCK_MHZ = 1'b0;

    // Reset value of the clock register and the sub-second radix
    localparam logic [CLK_MHZ_W-1:0] CLK_MHZ_RESET = 10'd168;
    localparam logic [CLK_MHZ_W-1:0] US_PER_MS     = 10'd1000;

    // Sequencer states
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Control of one bit-serial division stage
    typedef struct packed
    {
        logic clear;
        logic shift;
    } div_ctrl_t;

endpackage

/* rtl/ccts_serial_div.sv */
// One restoring division stage, one dividend bit per cycle while ctrl.shift is set, MSB first.
// Emits a quotient bit each step and keeps the running remainder.
// Depends on ccts_pkg.
module ccts_serial_div
(
    input  logic                           clk,
    input  ccts_pkg::div_ctrl_t            ctrl,
    input  logic [ccts_pkg::CLK_MHZ_W-1:0] divisor,
    input  logic                           bit_in,
    output logic                           q_bit,
    output logic [ccts_pkg::CLK_MHZ_W-1:0] rem
);
    import ccts_pkg::*;

    logic [CLK_MHZ_W-1:0] rem_reg;
    logic [CLK_MHZ_W-1:0] rem_next;
    logic [CLK_MHZ_W:0]   trial;

    // Bring in the next bit, subtract when the divisor fits
    always_comb
    begin
        trial    = {rem_reg, bit_in};
        q_bit    = (trial >= {1'b0, divisor});
        rem_next = rem_reg;
        if (ctrl.clear)
        begin
            rem_next = '0;
        end
        else if (ctrl.shift)
        begin
            if (q_bit)
            begin
                rem_next = CLK_MHZ_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[CLK_MHZ_W-1:0];
            end
        end
    end

    // Hold the remainder
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign rem = rem_reg;

endmodule

/* rtl/cycle_count_timestamp_split_unit.sv */
// Top level of the cycle-count timestamp splitter.
// Depends on ccts_pkg and ccts_serial_div.
//
// Usage:
//   s_tdata carries one raw sample of a free-running counter (low COUNT_BITS
//   bits used). The block extends it with a wrap count (a sample below the
//   previous one is a wrap), divides the extended count by clock_mhz
//   (0 taken as 1) and splits the microseconds into seconds, ms and us.
//   m_tdata/m_tuser deliver one result per accepted sample, in order.
//   clock_mhz is written over the APB port at byte address 0 (reset 168);
//   write it only while no sample is in flight.
// Operation:
//   Three cascaded restoring dividers (by clock_mhz, by 1000, by 1000)
//   consume one bit of the extended count per cycle; an item is loaded,
//   shifted through all WRAP_W + COUNT_BITS bits and then handed over.
//   One item is worked on at a time.
// Reset:
//   Clears the wrap count, the previous sample and the output valid, and
//   sets clock_mhz to 168.
// Stall:
//   A finished result waits in the output register; the next sample is
//   accepted meanwhile, and its result waits in the divider until the
//   output register is free.
module cycle_count_timestamp_split_unit
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ccts_pkg::IN_W-1:0]       s_tdata,   // [31:0] cycle_count
    // Output channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [44:0] seconds, [54:45] milliseconds, [64:55] microseconds,
    // [128:65] total_microseconds, [135:129] zero
    output logic [135:0]                    m_tdata,
    output logic                            m_tuser,   // [0] wrapped
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ccts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ccts_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ccts_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ccts_pkg::*;

    localparam int EXT_W = WRAP_W + COUNT_BITS;
    localparam int CNT_W = $clog2(EXT_W);

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CLK_MHZ_W-1:0] clock_mhz_reg, clock_mhz_next;
    logic [WRAP_W-1:0]    wrap_count_reg, wrap_count_next;
    logic [COUNT_BITS-1:0] last_sample_reg, last_sample_next;
    logic                 out_valid_reg, out_valid_next;

    // Datapath
    logic [EXT_W-1:0]     ext_reg;
    logic [SECONDS_W-1:0] secs_reg;
    logic                 wrapped_reg;
    logic [SECONDS_W-1:0]  out_secs_reg;
    logic [SUBSEC_W-1:0]   out_ms_reg;
    logic [SUBSEC_W-1:0]   out_us_reg;
    logic [TOTAL_US_W-1:0] out_total_reg;
    logic                  out_wrapped_reg;

    logic                  accept;
    logic                  load_out;
    logic                  is_wrap;
    logic [COUNT_BITS-1:0] sample;
    logic                  cfg_write;
    logic [CLK_MHZ_W-1:0]  div_val;
    div_ctrl_t             div_ctrl;
    logic                  q_a, q_b, q_c;
    logic [CLK_MHZ_W-1:0]  rem_a, rem_b, rem_c;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CLOCK_MHZ);
    assign prdata    = (paddr[2] == REG_CLOCK_MHZ) ? APB_DATA_W'(clock_mhz_reg) : '0;
    assign clock_mhz_next = cfg_write ? pwdata[CLK_MHZ_W-1:0] : clock_mhz_reg;

    // A zero clock divides by one
    assign div_val = (clock_mhz_reg == '0) ? CLK_MHZ_W'(1) : clock_mhz_reg;

    // Wrap detection on the incoming sample
    assign sample           = s_tdata[COUNT_BITS-1:0];
    assign is_wrap          = (sample < last_sample_reg);
    assign accept           = s_tvalid && s_tready;
    assign wrap_count_next  = (accept && is_wrap) ? wrap_count_reg + WRAP_W'(1) : wrap_count_reg;
    assign last_sample_next = accept ? sample : last_sample_reg;

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        s_tready       = 1'b0;
        load_out       = 1'b0;
        div_ctrl.clear = 1'b0;
        div_ctrl.shift = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    div_ctrl.clear = 1'b1;
                    cnt_next       = CNT_W'(EXT_W - 1);
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                div_ctrl.shift = 1'b1;
                cnt_next       = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop on transfer
    always_comb
    begin
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            clock_mhz_reg   <= CLK_MHZ_RESET;
            wrap_count_reg  <= '0;
            last_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            clock_mhz_reg   <= clock_mhz_next;
            wrap_count_reg  <= wrap_count_next;
            last_sample_reg <= last_sample_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Extended count shifts out MSB first; the quotient by clock_mhz
    // shifts in at the bottom, so the register ends up holding total us
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ext_reg     <= {wrap_count_next, sample};
            wrapped_reg <= is_wrap;
        end
        else if (div_ctrl.shift)
        begin
            ext_reg  <= {ext_reg[EXT_W-2:0], q_a};
            secs_reg <= {secs_reg[SECONDS_W-2:0], q_c};
        end
    end

    // Divide by clock_mhz
    ccts_serial_div u_div_clk
    (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .divisor (div_val),
        .bit_in  (ext_reg[EXT_W-1]),
        .q_bit   (q_a),
        .rem     (rem_a)
    );

    // Divide total us by 1000: remainder is the microsecond part
    ccts_serial_div u_div_us
    (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .divisor (US_PER_MS),
        .bit_in  (q_a),
        .q_bit   (q_b),
        .rem     (rem_b)
    );

    // Divide total ms by 1000: remainder is the millisecond part
    ccts_serial_div u_div_ms
    (
        .clk     (clk),
        .ctrl    (div_ctrl),
        .divisor (US_PER_MS),
        .bit_in  (q_b),
        .q_bit   (q_c),
        .rem     (rem_c)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_secs_reg    <= secs_reg;
            out_ms_reg      <= rem_c;
            out_us_reg      <= rem_b;
            out_total_reg   <= TOTAL_US_W'(ext_reg);
            out_wrapped_reg <= wrapped_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_us_reg, out_ms_reg, out_secs_reg};
    assign m_tuser  = out_wrapped_reg;

    // Assertions
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN) && (cnt_reg == CNT_W'(EXT_W - 1)))
        else $error("sample accepted without starting a full division run");

    a_rem_clk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_a < div_val))
        else $error("clock divider remainder not below divisor");

    a_rem_sub: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (rem_b < US_PER_MS) && (rem_c < US_PER_MS))
        else $error("sub-second part out of range");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid && (state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule
